FILE: src/kwsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsm_pkg: shared types and constants for the k-way sorted merge
// Status codes, controller states and the records that travel along the
// row of list cells.
// ----------------------------------------------------------------------------
package kwsm_pkg;

  localparam int LISTS_DEF = 8;
  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int LIN_W     = 3;   // width of the list_index field
  localparam int IDX_W     = 6;   // list number inside the cell row, covers up to 64 lists

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_START,
    S_SCAN,
    S_POP,
    S_DONE
  } state_t;

  // Running minimum handed from cell to cell during a pop scan
  typedef struct packed {
    logic                     valid;
    logic                     found;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } token_t;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic                     load;
    logic                     pop;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

FILE: src/kwsm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsm_in_if: input item channel
// Valid/ready channel that carries one load or pop request.
// ----------------------------------------------------------------------------
interface kwsm_in_if;
  import kwsm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [LIN_W-1:0]         list_index;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output list_index, output value, input ready);
  modport sink   (input valid, input op, input list_index, input value, output ready);
endinterface

FILE: src/kwsm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsm_out_if: result channel
// Valid/ready channel that carries one status/value/last result.
// ----------------------------------------------------------------------------
interface kwsm_out_if;
  import kwsm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] out_value;
  logic                     last;

  modport source (output valid, output status, output out_value, output last, input ready);
  modport sink   (input valid, input status, input out_value, input last, output ready);
endinterface

FILE: src/k_way_sorted_merge.sv
`timescale 1ns / 1ps
// Flow: a load passes the load and done states, a pop the start, scan, pop and done states;
// done waits for a free output register. One item at a time: a new item is taken only in idle,
// and the pop's minimum search walks the cell row one cell a cycle.
// A result waiting on the output register does not block the next input transfer.
// Reset (rst_n low, synchronous) empties every list; stored values themselves are not cleared.
// ----------------------------------------------------------------------------
// k_way_sorted_merge: k-way merge of ascending lists
// LISTS cells, each a bounded FIFO. Loads append to one list, pops return the
// smallest head across all lists (lowest list wins ties) and remove it.
// ----------------------------------------------------------------------------
module k_way_sorted_merge #(
  parameter int LISTS = kwsm_pkg::LISTS_DEF,
  parameter int DEPTH = kwsm_pkg::DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  kwsm_in_if.sink  in_ch,
  kwsm_out_if.source out_ch
);
  import kwsm_pkg::*;

  localparam int TOT_W = $clog2(LISTS * DEPTH + 1);

  state_t                   state_r, state_nxt;
  logic [LIN_W-1:0]         item_idx_r;
  logic signed [DATA_W-1:0] item_val_r;
  token_t                   best_r;
  logic [TOT_W-1:0]         total_r;
  status_t                  res_status_r;
  logic signed [DATA_W-1:0] res_value_r;
  logic                     res_last_r;
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r;

  cmd_t                     cmd;
  token_t                   tok_start;
  token_t                   tok [LISTS+1];
  logic [LISTS-1:0]         full_vec;
  logic                     in_range, sel_full, load_ok, out_free, in_xfer;

  // --------------------------------------------------------------------------
  // Cell row: the running minimum enters at cell 0 and walks to the last cell
  // --------------------------------------------------------------------------
  assign tok[0] = tok_start;

  for (genvar g = 0; g < LISTS; g++) begin : g_cell
    kwsm_cell #(
      .DEPTH   (DEPTH),
      .CELL_ID (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1]),
      .full    (full_vec[g])
    );
  end

  // Decode the target list of a load: out-of-range behaves like a full list
  always_comb begin
    in_range = 1'b0;
    sel_full = 1'b0;
    for (int i = 0; i < LISTS; i++) begin
      if (IDX_W'(item_idx_r) == IDX_W'(i)) begin
        in_range = 1'b1;
        sel_full = full_vec[i];
      end
    end
    load_ok = in_range && !sel_full;
  end

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = in_ch.op ? S_START : S_LOAD;
        end
      end
      S_LOAD:  state_nxt = S_DONE;
      S_START: state_nxt = S_SCAN;
      S_SCAN: begin
        if (tok[LISTS].valid) begin
          state_nxt = S_POP;
        end
      end
      S_POP:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller outputs: input ready, cell commands, scan launch
  // --------------------------------------------------------------------------
  always_comb begin
    in_ch.ready = 1'b0;
    cmd         = '0;
    tok_start   = '0;
    case (state_r)
      S_IDLE: in_ch.ready = 1'b1;
      S_LOAD: begin
        cmd.load  = load_ok;
        cmd.index = IDX_W'(item_idx_r);
        cmd.value = item_val_r;
      end
      S_START: tok_start.valid = 1'b1;
      S_POP: begin
        cmd.pop   = best_r.found;
        cmd.index = best_r.index;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Item capture, result formation and the stored-element total
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_idx_r <= in_ch.list_index;
      item_val_r <= in_ch.value;
    end
    if (state_r == S_SCAN && tok[LISTS].valid) begin
      best_r <= tok[LISTS];
    end
    if (state_r == S_LOAD) begin
      res_status_r <= load_ok ? ST_LOADED : ST_FULL;
      res_value_r  <= '0;
      res_last_r   <= 1'b0;
    end
    if (state_r == S_POP) begin
      res_status_r <= best_r.found ? ST_POPPED : ST_EMPTY;
      res_value_r  <= best_r.found ? best_r.value : '0;
      // last when the element leaving is the only one stored
      res_last_r   <= best_r.found && (total_r == TOT_W'(1));
    end
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_last_r   <= res_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_LOAD && load_ok) begin
        total_r <= total_r + 1'b1;
      end else if (state_r == S_POP && best_r.found) begin
        total_r <= total_r - 1'b1;
      end
      // Hold the result until its transfer; refill from the done state
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.last      = out_last_r;

endmodule

FILE: src/kwsm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsm_cell: one list of the merge
// Holds a circular FIFO of DEPTH values with its pointers and fill count,
// and compares its head against the running minimum passing by.
// ----------------------------------------------------------------------------
module kwsm_cell #(
  parameter int DEPTH   = kwsm_pkg::DEPTH_DEF,
  parameter int CELL_ID = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  kwsm_pkg::cmd_t   cmd,
  input  kwsm_pkg::token_t tok_in,
  output kwsm_pkg::token_t tok_out,
  output logic            full
);
  import kwsm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] head_r;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  token_t            tok_r, tok_nxt;
  logic              hit, do_load, do_pop, take;

  assign hit     = (cmd.index == IDX_W'(CELL_ID));
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_load = cmd.load && hit && !full;
  assign do_pop  = cmd.pop && hit && (count_r != '0);

  // Storage: one write port, registered read of the head entry
  always_ff @(posedge clk) begin
    if (do_load) begin
      mem[wr_ptr_r] <= cmd.value;
    end
    head_r <= mem[rd_ptr_r];
  end

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (do_load) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end
  end

  // Take the head when no minimum is found yet, else only on a strictly smaller head: ties stay low
  always_comb begin
    take    = tok_in.valid && (count_r != '0) &&
              (!tok_in.found || ($signed(head_r) < tok_in.value));
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.index = IDX_W'(CELL_ID);
      tok_nxt.value = $signed(head_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
      tok_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      tok_r    <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: src/kwsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsm_checker: port-level checks for the k-way sorted merge
// Watches both channels of the top level and flags illegal behavior.
// ----------------------------------------------------------------------------
module kwsm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [1:0]                      out_status,
  input logic signed [kwsm_pkg::DATA_W-1:0] out_value,
  input logic                            out_last
);
  import kwsm_pkg::*;

  // A stalled result holds its status and value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_value))
    else $error("result changed while stalled");

  // Only a popped result carries a value or a last flag
  a_no_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_POPPED) |-> (out_value == '0) && !out_last)
    else $error("non-pop result carries value or last");

  // One item at a time: no new transfer right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in back-to-back cycles");

  // A result never appears in the cycle after its item is taken
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised too early");

endmodule

bind k_way_sorted_merge kwsm_checker u_kwsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_value  (out_ch.out_value),
  .out_last   (out_ch.last)
);
